FILE: design/qs_pkg.sv
package qs_pkg;

    localparam int COMP_WIDTH = 16;

    localparam int Q_W      = 16;
    localparam int QN_W     = 17;
    localparam int T_W      = 16;
    localparam int COS_W    = 19;
    localparam int TH_W     = 17;
    localparam int ANG_W    = 31;
    localparam int SIN_W    = 32;
    localparam int FRAC     = 30;
    localparam int MAG_W    = 30;
    localparam int SQ_W     = 64;
    localparam int REM_W    = 46;
    localparam int QUO_W    = 15;
    localparam int MARGIN_W = 11;

    localparam int ONE_Q14      = 16384;
    localparam int ONE_T        = 32768;
    localparam int QUARTER_TURN = 65536;
    localparam int COS_ROUND    = 8192;

    localparam logic [SIN_W-1:0] SIN_C1 = 32'd1686629713;
    localparam logic [SIN_W-1:0] SIN_C3 = 32'd693598669;
    localparam logic [SIN_W-1:0] SIN_C5 = 32'd85569278;
    localparam logic [SIN_W-1:0] SIN_C7 = 32'd5026991;
    localparam logic [SIN_W-1:0] SIN_C9 = 32'd172272;

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] first_w;
        logic signed [COMP_WIDTH-1:0] first_x;
        logic signed [COMP_WIDTH-1:0] first_y;
        logic signed [COMP_WIDTH-1:0] first_z;
        logic signed [COMP_WIDTH-1:0] other_w;
        logic signed [COMP_WIDTH-1:0] other_x;
        logic signed [COMP_WIDTH-1:0] other_y;
        logic signed [COMP_WIDTH-1:0] other_z;
        logic [T_W-1:0]               blend;
    } req_t;

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] out_w;
        logic signed [COMP_WIDTH-1:0] out_x;
        logic signed [COMP_WIDTH-1:0] out_y;
        logic signed [COMP_WIDTH-1:0] out_z;
        logic                         used_linear;
    } rsp_t;

    typedef struct packed {
        logic [3:0][Q_W-1:0]  p;
        logic [3:0][QN_W-1:0] q;
        logic [T_W-1:0]       t;
        logic [COS_W-1:0]     cosq;
        logic                 lin;
    } front_t;

    typedef struct packed {
        logic [3:0][MAG_W-1:0] mag;
        logic [3:0]            neg;
        logic                  lin;
    } norm_t;

    typedef struct packed {
        logic [3:0][REM_W-1:0] rem;
        logic [3:0][QUO_W-1:0] quo;
        logic [31:0]           d;
        logic [3:0]            neg;
        logic                  lin;
        logic                  zero;
    } div_t;

    // horner coefficients from degree 7 down to 1
    function automatic logic [SIN_W-1:0] sin_coef(input int k);
        logic [SIN_W-1:0] c;
        case (k)
            0:       c = SIN_C7;
            1:       c = SIN_C5;
            2:       c = SIN_C3;
            3:       c = SIN_C1;
            default: c = SIN_C7;
        endcase
        return c;
    endfunction

endpackage

FILE: design/qs_sin_pipe.sv
module qs_sin_pipe #(
    parameter int SIDE_W = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      vin,
    input  logic [qs_pkg::ANG_W-1:0]  x,
    input  logic [SIDE_W-1:0]         side_in,
    output logic                      vout,
    output logic [qs_pkg::SIN_W-1:0]  s,
    output logic [SIDE_W-1:0]         side_out
);
    import qs_pkg::*;

    localparam int NST = 6;
    localparam logic [ANG_W-1:0] ONE30 = ANG_W'(1) << FRAC;

    logic [NST-1:0]    vld_reg;
    logic [SIDE_W-1:0] side_reg [NST];
    logic [ANG_W-1:0]  x_reg [NST-1];
    logic [ANG_W-1:0]  a2_reg [4];
    logic [SIN_W-1:0]  p_reg [4];
    logic [SIN_W-1:0]  s_reg;

    logic [ANG_W-1:0]       xc;
    logic [2*ANG_W-1:0]     sq;
    logic [SIN_W-1:0]       hprev [4];
    logic [SIN_W+ANG_W-1:0] hprod [4];
    logic [SIN_W-1:0]       p_next [4];
    logic [SIN_W+ANG_W-1:0] fprod;

    always_comb
    begin
        xc = (x > ONE30) ? ONE30 : x;
        sq = xc * xc;
        hprev[0] = SIN_C9;
        for (int k = 1; k < 4; k++)
        begin
            hprev[k] = p_reg[k-1];
        end
        for (int k = 0; k < 4; k++)
        begin
            hprod[k]  = hprev[k] * a2_reg[k];
            p_next[k] = sin_coef(k) - hprod[k][FRAC+SIN_W-1:FRAC];
        end
        fprod = p_reg[3] * x_reg[NST-2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], vin};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k < NST; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            x_reg[0]  <= xc;
            a2_reg[0] <= sq[FRAC+ANG_W-1:FRAC];
            for (int k = 1; k < NST-1; k++)
            begin
                x_reg[k] <= x_reg[k-1];
            end
            for (int k = 1; k < 4; k++)
            begin
                a2_reg[k] <= a2_reg[k-1];
            end
            for (int k = 0; k < 4; k++)
            begin
                p_reg[k] <= p_next[k];
            end
            s_reg <= fprod[FRAC+SIN_W-1:FRAC];
        end
    end

    assign vout     = vld_reg[NST-1];
    assign s        = s_reg;
    assign side_out = side_reg[NST-1];

endmodule

FILE: design/qs_acos_cell.sv
module qs_acos_cell #(
    parameter int BIT = 0
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     vin,
    input  logic [qs_pkg::TH_W-1:0]  a_in,
    input  qs_pkg::front_t           f_in,
    output logic                     vout,
    output logic [qs_pkg::TH_W-1:0]  a_out,
    output qs_pkg::front_t           f_out
);
    import qs_pkg::*;

    localparam int SIDE_W = $bits(front_t) + 2 * TH_W + 1;

    logic [TH_W-1:0]   cand;
    logic [TH_W-1:0]   diff;
    logic              ok;
    logic [ANG_W-1:0]  x;
    logic [SIDE_W-1:0] side_out;
    logic              sv;
    logic [SIN_W-1:0]  s;
    front_t            f_d;
    logic [TH_W-1:0]   a_d;
    logic [TH_W-1:0]   cand_d;
    logic              ok_d;
    logic              pass;

    logic              v_reg;
    logic [TH_W-1:0]   a_reg;
    front_t            f_reg;

    assign cand = a_in | (TH_W'(1) << BIT);
    assign ok   = cand <= TH_W'(QUARTER_TURN);
    assign diff = TH_W'(QUARTER_TURN) - cand;
    assign x    = {diff, 14'b0};

    qs_sin_pipe #(.SIDE_W(SIDE_W)) u_sin (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vin      (vin),
        .x        (x),
        .side_in  ({f_in, a_in, cand, ok}),
        .vout     (sv),
        .s        (s),
        .side_out (side_out)
    );

    assign {f_d, a_d, cand_d, ok_d} = side_out;
    // keep the candidate bit while the sine still reaches the cosine
    assign pass = ok_d && ({3'b0, s} >= {f_d.cosq, 16'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= sv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= pass ? cand_d : a_d;
            f_reg <= f_d;
        end
    end

    assign vout  = v_reg;
    assign a_out = a_reg;
    assign f_out = f_reg;

endmodule

FILE: design/qs_sqrt_cell.sv
module qs_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    vin,
    input  logic [qs_pkg::SQ_W-1:0] n_in,
    input  logic [qs_pkg::SQ_W-1:0] r_in,
    input  qs_pkg::norm_t           f_in,
    output logic                    vout,
    output logic [qs_pkg::SQ_W-1:0] n_out,
    output logic [qs_pkg::SQ_W-1:0] r_out,
    output qs_pkg::norm_t           f_out
);
    import qs_pkg::*;

    localparam logic [SQ_W-1:0] BVAL = SQ_W'(1) << (62 - 2 * STEP);

    logic [SQ_W-1:0] trial;
    logic [SQ_W-1:0] n_next;
    logic [SQ_W-1:0] r_next;
    logic            v_reg;
    logic [SQ_W-1:0] n_reg;
    logic [SQ_W-1:0] r_reg;
    norm_t           f_reg;

    always_comb
    begin
        trial = r_in + BVAL;
        if (n_in >= trial)
        begin
            n_next = n_in - trial;
            r_next = (r_in >> 1) + BVAL;
        end
        else
        begin
            n_next = n_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg <= n_next;
            r_reg <= r_next;
            f_reg <= f_in;
        end
    end

    assign vout  = v_reg;
    assign n_out = n_reg;
    assign r_out = r_reg;
    assign f_out = f_reg;

endmodule

FILE: design/qs_div_cell.sv
module qs_div_cell #(
    parameter int BIT = 0
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         vin,
    input  qs_pkg::div_t d_in,
    output logic         vout,
    output qs_pkg::div_t d_out
);
    import qs_pkg::*;

    logic [REM_W-1:0] dsh;
    div_t             d_next;
    logic             v_reg;
    div_t             d_reg;

    always_comb
    begin
        dsh    = REM_W'(d_in.d) << BIT;
        d_next = d_in;
        for (int i = 0; i < 4; i++)
        begin
            if (d_in.rem[i] >= dsh)
            begin
                d_next.rem[i]      = d_in.rem[i] - dsh;
                d_next.quo[i][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign vout  = v_reg;
    assign d_out = d_reg;

endmodule

FILE: design/quaternion_slerp.sv
// throughput: one request per cycle while the skid entry is free;
// every stage is a register step of the cell chain
// the acos bit search (17 cells of 7 stages), the square root (32 cells) and the
// divider (15 cells) set the depth; a two-entry output buffer decouples rsp_ready
// reset: rst_n clears all valid flags and the output buffer, margin returns to 1
module quaternion_slerp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  qs_pkg::req_t                    req_data,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output qs_pkg::rsp_t                    rsp_data,
    input  logic                            cfg_wr_en,
    input  logic [qs_pkg::MARGIN_W-1:0]     cfg_wr_data
);
    import qs_pkg::*;

    localparam int NACOS = TH_W;
    localparam int NSQRT = 32;
    localparam int NDIV  = QUO_W;

    logic                en;
    logic [MARGIN_W-1:0] margin_reg;

    // ---------------- load and products
    logic [COMP_WIDTH-1:0] raw_c [8];
    logic signed [Q_W-1:0] ld_c [8];
    logic [T_W-1:0]        t_sat;

    logic                  a_vld_reg;
    logic signed [Q_W-1:0] a_p_reg [4];
    logic signed [Q_W-1:0] a_q_reg [4];
    logic [T_W-1:0]        a_t_reg;
    logic signed [31:0]    a_prod_reg [4];

    assign raw_c[0] = req_data.first_w;
    assign raw_c[1] = req_data.first_x;
    assign raw_c[2] = req_data.first_y;
    assign raw_c[3] = req_data.first_z;
    assign raw_c[4] = req_data.other_w;
    assign raw_c[5] = req_data.other_x;
    assign raw_c[6] = req_data.other_y;
    assign raw_c[7] = req_data.other_z;

    for (genvar i = 0; i < 8; i++)
    begin : g_load
        if (COMP_WIDTH > Q_W)
        begin : g_down
            assign ld_c[i] = Q_W'($signed(raw_c[i]) >>> (COMP_WIDTH - Q_W));
        end
        else if (COMP_WIDTH == Q_W)
        begin : g_same
            assign ld_c[i] = raw_c[i];
        end
        else
        begin : g_up
            assign ld_c[i] = {raw_c[i], {(Q_W - COMP_WIDTH){1'b0}}};
        end
    end

    assign t_sat = (req_data.blend > T_W'(ONE_T)) ? T_W'(ONE_T) : req_data.blend;

    assign req_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= MARGIN_W'(1);
        end
        else if (cfg_wr_en)
        begin
            margin_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                a_p_reg[i]    <= ld_c[i];
                a_q_reg[i]    <= ld_c[4+i];
                a_prod_reg[i] <= ld_c[i] * ld_c[4+i];
            end
            a_t_reg <= t_sat;
        end
    end

    // ---------------- dot, short arc, cosine
    logic signed [33:0] dot;
    logic               dneg;
    logic [33:0]        adot;
    logic [33:0]        cos_sum;
    logic [COS_W-1:0]   cosq;
    logic [QN_W-1:0]    q17;
    front_t             b_f_next;

    logic               b_vld_reg;
    front_t             b_f_reg;

    always_comb
    begin
        dot = 34'(a_prod_reg[0]) + 34'(a_prod_reg[1])
            + 34'(a_prod_reg[2]) + 34'(a_prod_reg[3]);
        dneg    = dot[33];
        adot    = dneg ? 34'(-dot) : 34'(dot);
        cos_sum = adot + 34'(COS_ROUND);
        cosq    = cos_sum[COS_W+13:14];
        q17     = '0;
        for (int i = 0; i < 4; i++)
        begin
            q17 = {a_q_reg[i][Q_W-1], a_q_reg[i]};
            b_f_next.p[i] = a_p_reg[i];
            b_f_next.q[i] = dneg ? QN_W'(-q17) : q17;
        end
        b_f_next.t    = a_t_reg;
        b_f_next.cosq = cosq;
        b_f_next.lin  = (20'(cosq) + 20'(margin_reg)) > 20'(ONE_Q14);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_f_reg <= b_f_next;
        end
    end

    // ---------------- acos bit search
    logic            ac_v [NACOS+1];
    logic [TH_W-1:0] ac_a [NACOS+1];
    front_t          ac_f [NACOS+1];

    assign ac_v[0] = b_vld_reg;
    assign ac_a[0] = '0;
    assign ac_f[0] = b_f_reg;

    for (genvar k = 0; k < NACOS; k++)
    begin : g_acos
        qs_acos_cell #(.BIT(NACOS - 1 - k)) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .vin   (ac_v[k]),
            .a_in  (ac_a[k]),
            .f_in  (ac_f[k]),
            .vout  (ac_v[k+1]),
            .a_out (ac_a[k+1]),
            .f_out (ac_f[k+1])
        );
    end

    // ---------------- weight angles
    logic [TH_W-1:0]       th;
    front_t                fa;
    logic [TH_W-1:0]       tc17;
    logic [2*TH_W-1:0]     ta;
    logic [2*TH_W-1:0]     tb;

    logic                  w_vld_reg;
    logic [ANG_W-1:0]      w_xa_reg;
    logic [ANG_W-1:0]      w_xb_reg;
    logic [3:0][Q_W-1:0]   w_p_reg;
    logic [3:0][QN_W-1:0]  w_q_reg;
    logic [T_W-1:0]        w_t_reg;
    logic                  w_lin_reg;

    assign th   = ac_a[NACOS];
    assign fa   = ac_f[NACOS];
    assign tc17 = TH_W'(ONE_T) - TH_W'(fa.t);
    assign ta   = tc17 * th;
    assign tb   = TH_W'(fa.t) * th;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            w_vld_reg <= ac_v[NACOS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_xa_reg  <= {ta[31:15], 14'b0};
            w_xb_reg  <= {tb[31:15], 14'b0};
            w_p_reg   <= fa.p;
            w_q_reg   <= fa.q;
            w_t_reg   <= fa.t;
            // a zero angle falls back to the linear blend
            w_lin_reg <= fa.lin || (th == '0);
        end
    end

    // ---------------- sine weights
    localparam int SIDE0_W = 4 * Q_W + T_W + 1;
    localparam int SIDE1_W = 4 * QN_W;

    logic                 sv;
    logic [SIN_W-1:0]     s0;
    logic [SIN_W-1:0]     s1;
    logic [SIDE0_W-1:0]   side0;
    logic [SIDE1_W-1:0]   side1;

    qs_sin_pipe #(.SIDE_W(SIDE0_W)) u_sin0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vin      (w_vld_reg),
        .x        (w_xa_reg),
        .side_in  ({w_p_reg, w_t_reg, w_lin_reg}),
        .vout     (sv),
        .s        (s0),
        .side_out (side0)
    );

    qs_sin_pipe #(.SIDE_W(SIDE1_W)) u_sin1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vin      (w_vld_reg),
        .x        (w_xb_reg),
        .side_in  (w_q_reg),
        .vout     (),
        .s        (s1),
        .side_out (side1)
    );

    // ---------------- blend products
    logic [3:0][Q_W-1:0]   vp;
    logic [3:0][QN_W-1:0]  vq;
    logic [T_W-1:0]        vt;
    logic                  vlin;
    logic [T_W-1:0]        tcv;
    logic [ANG_W-1:0]      wa;
    logic [ANG_W-1:0]      wb;
    logic signed [47:0]    pw [4];
    logic signed [48:0]    qw [4];

    logic                  v_vld_reg;
    logic signed [47:0]    v_pw_reg [4];
    logic signed [48:0]    v_qw_reg [4];
    logic                  v_lin_reg;

    assign {vp, vt, vlin} = side0;
    assign vq  = side1;
    assign tcv = T_W'(ONE_T) - vt;
    assign wa  = vlin ? {tcv, 15'b0} : s0[ANG_W-1:0];
    assign wb  = vlin ? {vt, 15'b0} : s1[ANG_W-1:0];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            pw[i] = $signed({1'b0, wa}) * $signed(vp[i]);
            qw[i] = $signed({1'b0, wb}) * $signed(vq[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            v_vld_reg <= sv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                v_pw_reg[i] <= pw[i];
                v_qw_reg[i] <= qw[i];
            end
            v_lin_reg <= vlin;
        end
    end

    // ---------------- sum and magnitude
    logic signed [49:0] vsum [4];
    logic [46:0]        vmag [4];
    logic [3:0]         vneg;

    logic               s_vld_reg;
    logic [46:0]        s_mag_reg [4];
    logic [3:0]         s_neg_reg;
    logic               s_lin_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            vsum[i] = 50'(v_pw_reg[i]) + 50'(v_qw_reg[i]);
            vneg[i] = vsum[i][49];
            vmag[i] = vneg[i] ? 47'(-vsum[i]) : 47'(vsum[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s_vld_reg <= v_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_mag_reg <= vmag;
            s_neg_reg <= vneg;
            s_lin_reg <= v_lin_reg;
        end
    end

    // ---------------- largest magnitude
    logic [46:0] m01;
    logic [46:0] m23;

    logic        m_vld_reg;
    logic [46:0] m_mx_reg;
    logic [46:0] m_mag_reg [4];
    logic [3:0]  m_neg_reg;
    logic        m_lin_reg;

    assign m01 = (s_mag_reg[0] > s_mag_reg[1]) ? s_mag_reg[0] : s_mag_reg[1];
    assign m23 = (s_mag_reg[2] > s_mag_reg[3]) ? s_mag_reg[2] : s_mag_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            m_vld_reg <= s_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_mx_reg  <= (m01 > m23) ? m01 : m23;
            m_mag_reg <= s_mag_reg;
            m_neg_reg <= s_neg_reg;
            m_lin_reg <= s_lin_reg;
        end
    end

    // ---------------- scale shift
    logic [4:0]  sh;

    logic        h_vld_reg;
    logic [4:0]  h_sh_reg;
    logic [46:0] h_mag_reg [4];
    logic [3:0]  h_neg_reg;
    logic        h_lin_reg;

    // smallest shift that brings the largest magnitude under 2^30
    always_comb
    begin
        sh = '0;
        for (int j = MAG_W; j < 47; j++)
        begin
            if (m_mx_reg[j])
            begin
                sh = 5'(j - MAG_W + 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            h_vld_reg <= m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_sh_reg  <= sh;
            h_mag_reg <= m_mag_reg;
            h_neg_reg <= m_neg_reg;
            h_lin_reg <= m_lin_reg;
        end
    end

    // ---------------- shift, square, sum
    logic [46:0]       shifted [4];
    logic              x_vld_reg;
    logic [MAG_W-1:0]  x_mag_reg [4];
    logic [3:0]        x_neg_reg;
    logic              x_lin_reg;

    logic              q_vld_reg;
    logic [2*MAG_W-1:0] q_sq_reg [4];
    logic [MAG_W-1:0]  q_mag_reg [4];
    logic [3:0]        q_neg_reg;
    logic              q_lin_reg;

    logic              n_vld_reg;
    logic [61:0]       n_n2_reg;
    norm_t             n_nm_reg;
    norm_t             nm_next;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            shifted[i]    = h_mag_reg[i] >> h_sh_reg;
            nm_next.mag[i] = q_mag_reg[i];
        end
        nm_next.neg = q_neg_reg;
        nm_next.lin = q_lin_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_vld_reg <= 1'b0;
            q_vld_reg <= 1'b0;
            n_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            x_vld_reg <= h_vld_reg;
            q_vld_reg <= x_vld_reg;
            n_vld_reg <= q_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                x_mag_reg[i] <= shifted[i][MAG_W-1:0];
                q_sq_reg[i]  <= x_mag_reg[i] * x_mag_reg[i];
            end
            x_neg_reg <= h_neg_reg;
            x_lin_reg <= h_lin_reg;
            q_mag_reg <= x_mag_reg;
            q_neg_reg <= x_neg_reg;
            q_lin_reg <= x_lin_reg;
            n_n2_reg  <= 62'(q_sq_reg[0]) + 62'(q_sq_reg[1])
                       + 62'(q_sq_reg[2]) + 62'(q_sq_reg[3]);
            n_nm_reg  <= nm_next;
        end
    end

    // ---------------- square root
    logic            sq_v [NSQRT+1];
    logic [SQ_W-1:0] sq_n [NSQRT+1];
    logic [SQ_W-1:0] sq_r [NSQRT+1];
    norm_t           sq_f [NSQRT+1];

    assign sq_v[0] = n_vld_reg;
    assign sq_n[0] = SQ_W'(n_n2_reg);
    assign sq_r[0] = '0;
    assign sq_f[0] = n_nm_reg;

    for (genvar k = 0; k < NSQRT; k++)
    begin : g_sqrt
        qs_sqrt_cell #(.STEP(k)) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .vin   (sq_v[k]),
            .n_in  (sq_n[k]),
            .r_in  (sq_r[k]),
            .f_in  (sq_f[k]),
            .vout  (sq_v[k+1]),
            .n_out (sq_n[k+1]),
            .r_out (sq_r[k+1]),
            .f_out (sq_f[k+1])
        );
    end

    // ---------------- rounded division setup
    logic [31:0] nrm;
    norm_t       nf;
    div_t        d_next;
    logic        d_vld_reg;
    div_t        d_reg;

    assign nrm = sq_r[NSQRT][31:0];
    assign nf  = sq_f[NSQRT];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            d_next.rem[i] = REM_W'({nf.mag[i], 14'b0}) + REM_W'(nrm >> 1);
            d_next.quo[i] = '0;
        end
        d_next.d    = nrm;
        d_next.neg  = nf.neg;
        d_next.lin  = nf.lin;
        d_next.zero = (nrm == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            d_vld_reg <= sq_v[NSQRT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    logic dc_v [NDIV+1];
    div_t dc_d [NDIV+1];

    assign dc_v[0] = d_vld_reg;
    assign dc_d[0] = d_reg;

    for (genvar k = 0; k < NDIV; k++)
    begin : g_div
        qs_div_cell #(.BIT(NDIV - 1 - k)) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .vin   (dc_v[k]),
            .d_in  (dc_d[k]),
            .vout  (dc_v[k+1]),
            .d_out (dc_d[k+1])
        );
    end

    // ---------------- result format
    div_t                  dv;
    logic [Q_W-1:0]        mres [4];
    logic signed [Q_W-1:0] rs [4];
    logic [COMP_WIDTH-1:0] st [4];
    rsp_t                  last_data;
    logic                  last_vld;

    assign dv       = dc_d[NDIV];
    assign last_vld = dc_v[NDIV];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mres[i] = dv.zero ? '0 : {1'b0, dv.quo[i]};
            rs[i]   = dv.neg[i] ? $signed(-mres[i]) : $signed(mres[i]);
        end
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_store
        if (COMP_WIDTH > Q_W)
        begin : g_up
            assign st[i] = {rs[i], {(COMP_WIDTH - Q_W){1'b0}}};
        end
        else if (COMP_WIDTH == Q_W)
        begin : g_same
            assign st[i] = rs[i];
        end
        else
        begin : g_down
            assign st[i] = COMP_WIDTH'(rs[i] >>> (Q_W - COMP_WIDTH));
        end
    end

    assign last_data.out_w       = st[0];
    assign last_data.out_x       = st[1];
    assign last_data.out_y       = st[2];
    assign last_data.out_z       = st[3];
    assign last_data.used_linear = dv.lin;

    // ---------------- output register and skid entry
    logic ov_reg;
    logic ov_next;
    logic sk_vld_reg;
    logic sk_next;
    rsp_t od_reg;
    rsp_t sk_reg;
    logic load_out;
    logic load_skid;
    logic from_skid;

    // the chain only advances while the skid entry is free
    assign en = !sk_vld_reg;

    always_comb
    begin
        ov_next   = ov_reg;
        sk_next   = sk_vld_reg;
        load_out  = 1'b0;
        load_skid = 1'b0;
        from_skid = 1'b0;
        if (sk_vld_reg)
        begin
            if (rsp_ready)
            begin
                from_skid = 1'b1;
                sk_next   = 1'b0;
                ov_next   = 1'b1;
            end
        end
        else if (last_vld)
        begin
            if (!ov_reg || rsp_ready)
            begin
                load_out = 1'b1;
                ov_next  = 1'b1;
            end
            else
            begin
                load_skid = 1'b1;
                sk_next   = 1'b1;
            end
        end
        else if (rsp_ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg     <= 1'b0;
            sk_vld_reg <= 1'b0;
        end
        else
        begin
            ov_reg     <= ov_next;
            sk_vld_reg <= sk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (from_skid)
        begin
            od_reg <= sk_reg;
        end
        else if (load_out)
        begin
            od_reg <= last_data;
        end
        if (load_skid)
        begin
            sk_reg <= last_data;
        end
    end

    assign rsp_valid = ov_reg;
    assign rsp_data  = od_reg;

endmodule

FILE: verif/quaternion_slerp_tb.sv
module quaternion_slerp_tb;
    import qs_pkg::*;

    localparam int LATENCY     = 184;
    localparam int CYCLE_LIMIT = 400000;

    logic         clk;
    logic         rst_n;
    logic         req_valid;
    logic         req_ready;
    req_t         req_data;
    logic         rsp_valid;
    logic         rsp_ready;
    rsp_t         rsp_data;
    logic         cfg_wr_en;
    logic [MARGIN_W-1:0] cfg_wr_data;
    logic         req_accepted;

    req_t pending_reqs[$];
    rsp_t expected_quats[$];
    logic [MARGIN_W-1:0] margin_model;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   mismatches;
    int   cycles;

    quaternion_slerp u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_data    (req_data),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp_data    (rsp_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic longint floor_shift(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -(((-v) + ((longint'(1) << s) - 1)) >>> s);
    endfunction

    function automatic longint unsigned sine_q30(longint unsigned x);
        longint unsigned a2;
        longint unsigned p;
        if (x > (64'd1 << 30))
            x = 64'd1 << 30;
        a2 = (x * x) >> 30;
        p = SIN_C9;
        p = SIN_C7 - ((p * a2) >> 30);
        p = SIN_C5 - ((p * a2) >> 30);
        p = SIN_C3 - ((p * a2) >> 30);
        p = SIN_C1 - ((p * a2) >> 30);
        return (p * x) >> 30;
    endfunction

    function automatic longint unsigned arc_cos(longint unsigned c);
        longint unsigned a;
        longint unsigned cand;
        a = 0;
        for (int b = 16; b >= 0; b--)
        begin
            cand = a | (64'd1 << b);
            if (cand <= QUARTER_TURN &&
                sine_q30((QUARTER_TURN - cand) << 14) >= (c << 16))
                a = cand;
        end
        return a;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic rsp_t slerp_quat(req_t r, logic [MARGIN_W-1:0] margin);
        longint p[4];
        longint q[4];
        longint v[4];
        longint unsigned mag[4];
        longint dot;
        longint w0;
        longint w1;
        longint res;
        longint unsigned t;
        longint unsigned cosq;
        longint unsigned theta;
        longint unsigned mx;
        longint unsigned n2;
        longint unsigned nrm;
        int   sh;
        logic linear;
        logic signed [COMP_WIDTH-1:0] o[4];
        rsp_t e;
        p[0] = r.first_w; p[1] = r.first_x; p[2] = r.first_y; p[3] = r.first_z;
        q[0] = r.other_w; q[1] = r.other_x; q[2] = r.other_y; q[3] = r.other_z;
        dot = 0;
        for (int i = 0; i < 4; i++)
            dot += p[i] * q[i];
        t = r.blend;
        if (t > ONE_T)
            t = ONE_T;
        if (dot < 0)
        begin
            for (int i = 0; i < 4; i++)
                q[i] = -q[i];
            dot = -dot;
        end
        cosq = (longint'(dot) + 8192) >> 14;
        linear = (cosq + margin > ONE_Q14);
        theta = 0;
        if (!linear)
        begin
            theta = arc_cos(cosq);
            if (theta == 0)
                linear = 1'b1;
        end
        if (linear)
        begin
            w0 = (ONE_T - t) << 15;
            w1 = t << 15;
        end
        else
        begin
            w0 = sine_q30((((ONE_T - t) * theta) >> 15) << 14);
            w1 = sine_q30(((t * theta) >> 15) << 14);
        end
        mx = 0;
        for (int i = 0; i < 4; i++)
        begin
            v[i] = w0 * p[i] + w1 * q[i];
            mag[i] = (v[i] < 0) ? -v[i] : v[i];
            if (mag[i] > mx)
                mx = mag[i];
        end
        sh = 0;
        while ((mx >> sh) >= (64'd1 << 30))
            sh++;
        n2 = 0;
        for (int i = 0; i < 4; i++)
        begin
            mag[i] >>= sh;
            n2 += mag[i] * mag[i];
        end
        nrm = int_sqrt(n2);
        for (int i = 0; i < 4; i++)
        begin
            res = 0;
            if (nrm != 0)
                res = (mag[i] * ONE_Q14 + (nrm >> 1)) / nrm;
            if (v[i] < 0)
                res = -res;
            o[i] = res[COMP_WIDTH-1:0];
        end
        e.out_w = o[0];
        e.out_x = o[1];
        e.out_y = o[2];
        e.out_z = o[3];
        e.used_linear = linear;
        return e;
    endfunction

    function automatic logic signed [15:0] rand_comp();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 16'($urandom);
        if (k == 1)
            return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic logic [15:0] rand_blend();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 16'($urandom);
        if (k == 1)
            return $urandom_range(0, 1) ? 16'd0 : 16'd32768;
        return 16'($urandom_range(0, 32768));
    endfunction

    function automatic req_t make_req(logic signed [15:0] pw, px, py, pz,
                                      logic signed [15:0] qw, qx, qy, qz,
                                      logic [15:0] t);
        req_t r;
        r.first_w = pw; r.first_x = px; r.first_y = py; r.first_z = pz;
        r.other_w = qw; r.other_x = qx; r.other_y = qy; r.other_z = qz;
        r.blend = t;
        return r;
    endfunction

    function automatic req_t rand_req();
        req_t r;
        int   k;
        r = make_req(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                     rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_blend());
        k = $urandom_range(0, 5);
        // near-parallel pairs so the linear and small-angle paths get hit
        if (k == 0)
        begin
            r.other_w = r.first_w + 16'($signed($urandom_range(0, 64)) - 32);
            r.other_x = r.first_x + 16'($signed($urandom_range(0, 64)) - 32);
            r.other_y = r.first_y + 16'($signed($urandom_range(0, 64)) - 32);
            r.other_z = r.first_z + 16'($signed($urandom_range(0, 64)) - 32);
        end
        else if (k == 1)
        begin
            r.other_w = -r.first_w;
            r.other_x = -r.first_x + 16'($signed($urandom_range(0, 8)) - 4);
            r.other_y = -r.first_y;
            r.other_z = -r.first_z;
        end
        return r;
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_accepted)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(1, 100) > send_idle_pct)
                begin
                    req_data <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
            rsp_ready <= ($urandom_range(1, 100) > recv_idle_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        // request taken at this rising edge
        req_accepted <= rst_n && req_valid && req_ready;
        if (rst_n && req_valid && req_ready)
            expected_quats.push_back(slerp_quat(req_data, margin_model));
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_quats.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected response %p", rsp_data);
            end
            else if (rsp_data !== expected_quats[0])
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("mismatch: expected %p got %p", expected_quats[0], rsp_data);
                void'(expected_quats.pop_front());
            end
            else
                void'(expected_quats.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("quaternion_slerp verification failed");
            $finish;
        end
    end

    task automatic drain();
        while (pending_reqs.size() > 0 || req_valid || expected_quats.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_margin(logic [MARGIN_W-1:0] m);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        margin_model = m;
    endtask

    task automatic run_phase(int n, logic [MARGIN_W-1:0] m, int s_idle, int r_idle);
        write_margin(m);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int i = 0; i < n; i++)
            pending_reqs.push_back(rand_req());
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        rsp_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        margin_model = 1;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        mismatches = 0;
        cycles = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: identical, opposite, orthogonal, extremes, oversized blend
        pending_reqs.push_back(make_req(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        pending_reqs.push_back(make_req(16384, 0, 0, 0, -16384, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(16384, 0, 0, 0, 0, 16384, 0, 0, 16384));
        pending_reqs.push_back(make_req(16384, 0, 0, 0, 0, 16384, 0, 0, 0));
        pending_reqs.push_back(make_req(16384, 0, 0, 0, 0, 16384, 0, 0, 32768));
        pending_reqs.push_back(make_req(16384, 0, 0, 0, 0, 16384, 0, 0, 16'hffff));
        pending_reqs.push_back(make_req(11585, 11585, 0, 0, 0, 0, 11585, -11585, 8000));
        pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 0, 0, 0, 16384));
        pending_reqs.push_back(make_req(16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
        pending_reqs.push_back(make_req(32767, 32767, 32767, 32767,
                                        -32768, -32768, -32768, -32768, 20000));
        pending_reqs.push_back(make_req(-32768, 32767, -32768, 32767,
                                        -32768, 32767, -32768, 32767, 1));
        pending_reqs.push_back(make_req(16384, 0, 0, 0, 16380, 300, 0, 0, 10000));
        pending_reqs.push_back(make_req(16384, 0, 0, 0, 16000, 3500, 0, 0, 10000));
        pending_reqs.push_back(make_req(8192, 8192, 8192, 8192,
                                        -8192, 8192, -8192, 8192, 32767));
        pending_reqs.push_back(make_req(100, -200, 300, -400, 50, 60, -70, 80, 12345));
        drain();

        run_phase(600, 1, 26, 67);
        run_phase(300, 11'd1024, 67, 26);
        run_phase(300, 0, 67, 26);
        run_phase(250, 11'd2047, 0, 0);
        run_phase(300, 11'd200, 0, 0);

        if (mismatches == 0)
            $display("quaternion_slerp verification clean");
        else
            $display("quaternion_slerp verification failed");
        $finish;
    end

endmodule

FILE: quaternion_slerp.f
design/qs_pkg.sv
design/qs_sin_pipe.sv
design/qs_acos_cell.sv
design/qs_sqrt_cell.sv
design/qs_div_cell.sv
design/quaternion_slerp.sv
verif/quaternion_slerp_tb.sv
